// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the vertex welder.
// Depends on nothing; the using scope must hold clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define VWR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define VWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/vwr_pkg.sv =====
// Types, codes and helper functions of the vertex welder.
// Depends on nothing; used by every RTL file but vwr_ram and assert_macros.svh.
`default_nettype none

package vwr_pkg;

  localparam int IDX_W   = 10;
  localparam int COORD_W = 32;

  typedef enum logic [1:0] {
    OP_VERTEX   = 2'd0,
    OP_TRIANGLE = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_UNSEEN = 2'd2;

  localparam logic [COORD_W-1:0] NEG_ZERO = 32'h8000_0000;

  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_B = 2'd1,
    SEL_C = 2'd2
  } corner_sel_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic [IDX_W-1:0]   corner_a;
    logic [IDX_W-1:0]   corner_b;
    logic [IDX_W-1:0]   corner_c;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             is_new;
    logic             kept;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_c;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load;
    logic        scan_clr;
    logic        scan_inc;
    logic        hit_commit;
    logic        miss_commit;
    corner_sel_t tri_sel;
    logic        lat_a;
    logic        lat_b;
    logic        tri_fin;
    logic        res_zero;
    logic        res_full;
    logic        clear;
    logic        out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic vfull;
    logic uzero;
    logic match;
    logic scan_last;
    logic out_free;
  } stat_t;

  // Minus zero is folded onto plus zero so that the two weld together.
  function automatic logic [COORD_W-1:0] canon_coord(input logic [COORD_W-1:0] v);
    return (v == NEG_ZERO) ? '0 : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vwr_if.sv =====
// Valid/ready channel interfaces for the input and result beats.
// Depends on vwr_pkg for the payload types.
`default_nettype none

interface vwr_in_if;
  logic              valid;
  logic              ready;
  vwr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vwr_out_if;
  logic               valid;
  logic               ready;
  vwr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/vwr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module vwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/vwr_ctrl.sv =====
// Controller state machine of the vertex welder.
// Depends on vwr_pkg for the command and status structs.
`default_nettype none

module vwr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire vwr_pkg::stat_t  stat,
  output vwr_pkg::cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_MISS,
    S_TB,
    S_TC,
    S_TD,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.tri_sel = vwr_pkg::SEL_A;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.op)
          vwr_pkg::OP_VERTEX: begin
            if (stat.vfull) begin
              cmd.res_full = 1'b1;
              state_nxt    = S_DONE;
            end else if (stat.uzero) begin
              state_nxt = S_MISS;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
          vwr_pkg::OP_TRIANGLE: begin
            cmd.tri_sel = vwr_pkg::SEL_A;
            state_nxt   = S_TB;
          end
          vwr_pkg::OP_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.res_zero = 1'b1;
            state_nxt    = S_DONE;
          end
          default: begin
            cmd.res_zero = 1'b1;
            state_nxt    = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.hit_commit = 1'b1;
          state_nxt      = S_DONE;
        end else if (stat.scan_last) begin
          state_nxt = S_MISS;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_MISS: begin
        cmd.miss_commit = 1'b1;
        state_nxt       = S_DONE;
      end
      S_TB: begin
        cmd.lat_a   = 1'b1;
        cmd.tri_sel = vwr_pkg::SEL_B;
        state_nxt   = S_TC;
      end
      S_TC: begin
        cmd.lat_b   = 1'b1;
        cmd.tri_sel = vwr_pkg::SEL_C;
        state_nxt   = S_TD;
      end
      S_TD: begin
        cmd.tri_fin = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vwr_datapath.sv =====
// Datapath of the vertex welder: item register, counters, position and remap
// memories, result and output registers. Depends on vwr_pkg, vwr_if, vwr_ram.
`default_nettype none

module vwr_datapath #(
  parameter int VERTEX_CAPACITY = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire vwr_pkg::in_item_t in_data,
  input  wire vwr_pkg::cmd_t     cmd,
  output vwr_pkg::stat_t         stat,
  vwr_out_if.source              out_ch
);

  localparam int AW = $clog2(VERTEX_CAPACITY);
  localparam int CW = $clog2(VERTEX_CAPACITY + 1);
  localparam int XW = (CW > vwr_pkg::IDX_W) ? CW : vwr_pkg::IDX_W;
  localparam int KW = 3 * vwr_pkg::COORD_W;

  vwr_pkg::in_item_t  item_r;
  logic [KW-1:0]      key_r;
  logic [CW-1:0]      vcnt_r, vcnt_nxt;
  logic [CW-1:0]      ucnt_r, ucnt_nxt;
  logic [AW-1:0]      scan_r, scan_nxt;
  logic [AW:0]        ent_a_r, ent_b_r;
  vwr_pkg::out_item_t res_r, res_nxt;
  vwr_pkg::out_item_t out_r;
  logic               out_valid_r, out_valid_nxt;

  logic [KW-1:0]         pos_rdata;
  logic                  pos_we;
  logic [AW:0]           map_rdata, map_wdata;
  logic                  map_we;
  logic [AW-1:0]         map_raddr;
  logic [vwr_pkg::IDX_W-1:0] corner_sel;
  logic                  ufull;
  logic                  ok_a, ok_b, ok_c;
  logic [AW-1:0]         ra, rb, rc;

  // Index of the store widened or cut to the 10-bit result field.
  function automatic logic [vwr_pkg::IDX_W-1:0] to_idx(input logic [AW-1:0] v);
    logic [XW-1:0] t;
    t = XW'(v);
    return t[vwr_pkg::IDX_W-1:0];
  endfunction

  // Corner number to store address; the range check guards the cut.
  function automatic logic [AW-1:0] to_addr(input logic [vwr_pkg::IDX_W-1:0] c);
    logic [XW-1:0] t;
    t = XW'(c);
    return t[AW-1:0];
  endfunction

  // A corner is assigned when it is below the vertex count and its entry is valid.
  function automatic logic corner_ok(input logic [vwr_pkg::IDX_W-1:0] c,
                                     input logic [CW-1:0] vcnt,
                                     input logic [AW:0] ent);
    return (XW'(c) < XW'(vcnt)) && (XW'(c) < XW'(VERTEX_CAPACITY)) && ent[AW];
  endfunction

  assign ufull = (ucnt_r == CW'(VERTEX_CAPACITY));

  // Status towards the controller.
  always_comb begin
    stat.op        = vwr_pkg::op_t'(item_r.op);
    stat.vfull     = (vcnt_r == CW'(VERTEX_CAPACITY));
    stat.uzero     = (ucnt_r == '0);
    stat.match     = (pos_rdata == key_r);
    stat.scan_last = ((CW'(scan_r) + CW'(1)) == ucnt_r);
    stat.out_free  = !out_valid_r || out_ch.ready;
  end

  // Scan pointer; the read address runs one step ahead of the compared entry.
  always_comb begin
    scan_nxt = scan_r;
    if (cmd.scan_clr) begin
      scan_nxt = '0;
    end else if (cmd.scan_inc) begin
      scan_nxt = scan_r + AW'(1);
    end
  end

  // Remap read address follows the corner being fetched.
  always_comb begin
    case (cmd.tri_sel)
      vwr_pkg::SEL_B: corner_sel = item_r.corner_b;
      vwr_pkg::SEL_C: corner_sel = item_r.corner_c;
      default:        corner_sel = item_r.corner_a;
    endcase
  end
  assign map_raddr = to_addr(corner_sel);

  // Remap store writes on a hit or a miss; position store only on a miss with room.
  assign pos_we    = cmd.miss_commit && !ufull;
  assign map_we    = cmd.hit_commit || cmd.miss_commit;
  always_comb begin
    if (cmd.hit_commit) begin
      map_wdata = {1'b1, scan_r};
    end else if (ufull) begin
      map_wdata = '0;
    end else begin
      map_wdata = {1'b1, ucnt_r[AW-1:0]};
    end
  end

  assign ra   = ent_a_r[AW-1:0];
  assign rb   = ent_b_r[AW-1:0];
  assign rc   = map_rdata[AW-1:0];
  assign ok_a = corner_ok(item_r.corner_a, vcnt_r, ent_a_r);
  assign ok_b = corner_ok(item_r.corner_b, vcnt_r, ent_b_r);
  assign ok_c = corner_ok(item_r.corner_c, vcnt_r, map_rdata);

  // Counters and result build-up.
  always_comb begin
    vcnt_nxt = vcnt_r;
    ucnt_nxt = ucnt_r;
    res_nxt  = res_r;
    if (cmd.clear) begin
      vcnt_nxt = '0;
      ucnt_nxt = '0;
    end
    if (cmd.res_zero) begin
      res_nxt = '0;
    end
    if (cmd.res_full) begin
      res_nxt        = '0;
      res_nxt.status = vwr_pkg::ST_FULL;
    end
    if (cmd.hit_commit) begin
      vcnt_nxt        = vcnt_r + CW'(1);
      res_nxt         = '0;
      res_nxt.index_a = to_idx(scan_r);
    end
    if (cmd.miss_commit) begin
      vcnt_nxt = vcnt_r + CW'(1);
      res_nxt  = '0;
      if (ufull) begin
        res_nxt.status = vwr_pkg::ST_FULL;
      end else begin
        ucnt_nxt        = ucnt_r + CW'(1);
        res_nxt.is_new  = 1'b1;
        res_nxt.index_a = to_idx(ucnt_r[AW-1:0]);
      end
    end
    if (cmd.tri_fin) begin
      res_nxt = '0;
      if (ok_a && ok_b && ok_c) begin
        res_nxt.index_a = to_idx(ra);
        res_nxt.index_b = to_idx(rb);
        res_nxt.index_c = to_idx(rc);
        res_nxt.kept    = (ra != rb) && (rb != rc) && (ra != rc);
      end else begin
        res_nxt.status = vwr_pkg::ST_UNSEEN;
      end
    end
  end

  // Output valid: set on load, dropped once the beat is taken.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= '0;
      ucnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vcnt_r      <= vcnt_nxt;
      ucnt_r      <= ucnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      key_r  <= {vwr_pkg::canon_coord(in_data.pos_x),
                 vwr_pkg::canon_coord(in_data.pos_y),
                 vwr_pkg::canon_coord(in_data.pos_z)};
    end
    if (cmd.lat_a) begin
      ent_a_r <= map_rdata;
    end
    if (cmd.lat_b) begin
      ent_b_r <= map_rdata;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
    scan_r <= scan_nxt;
    res_r  <= res_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Unique positions, indexed by unique index.
  vwr_ram #(
    .WIDTH (KW),
    .DEPTH (VERTEX_CAPACITY)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (ucnt_r[AW-1:0]),
    .wdata (key_r),
    .raddr (scan_nxt),
    .rdata (pos_rdata)
  );

  // Remap store with its valid flag on top, indexed by arrival number.
  vwr_ram #(
    .WIDTH (AW + 1),
    .DEPTH (VERTEX_CAPACITY)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (vcnt_r[AW-1:0]),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/vertex_weld_remap.sv =====
// Top level of the vertex welder: controller, datapath and assertions.
// Depends on vwr_pkg, vwr_if, vwr_ctrl, vwr_datapath and assert_macros.svh.
//
// Usage: items arrive as beats on in_ch (valid/ready), one result beat per
// item leaves on out_ch. A vertex beat searches the unique position memory
// one entry per cycle from index 0 until it matches, then records its unique
// index in the remap memory at its arrival number; a new position is appended.
// Each vertex beat compares entries in the scan until one matches; a new
// vertex scans every unique entry (none when the table is empty) before it
// is appended. A triangle makes three remap reads through one read port;
// clear, unused codes and a vertex that finds the remap store full go
// straight to the result. One item is in work at a time; the next is taken
// the cycle after the result has moved into the output register, and a
// waiting result does not hold off the next item. A clear beat only resets
// the two fill counts, so it takes no sweep of the memories.
// Reset (rst_n low at a clock edge) empties both tables and drops out_ch.valid.
// When the receiver stalls, the result is held in the output register and the
// finished item waits until that register frees before completing.
`default_nettype none
`include "assert_macros.svh"

module vertex_weld_remap #(
  parameter int VERTEX_CAPACITY = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vwr_in_if.sink     in_ch,
  vwr_out_if.source  out_ch
);

  vwr_pkg::cmd_t  cmd;
  vwr_pkg::stat_t stat;
  logic           in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer.
  vwr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  vwr_datapath #(
    .VERTEX_CAPACITY (VERTEX_CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_ch.data),
    .cmd     (cmd),
    .stat    (stat),
    .out_ch  (out_ch)
  );

  // An accepted item closes the input in the cycle after it is taken.
  `VWR_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ready, !in_ready, "input stayed open after accept")

  // A result only appears as the controller returns to idle.
  `VWR_ASSERT_NOW(a_out_rise_idle, $rose(out_ch.valid), in_ready, "result raised while still busy")

  // The output register is never loaded over a waiting result.
  `VWR_ASSERT_NOW(a_no_overwrite, cmd.out_load, stat.out_free, "output overwritten while stalled")

endmodule

`default_nettype wire

// ===== sim/vwr_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench copy point for the channel interfaces is the RTL's vwr_if.sv.
// This file only holds a small helper package of test constants; depends on vwr_pkg.
package vwr_tb_pkg;
  import vwr_pkg::*;

  // Number of vertex slots in the instance under test.
  localparam int CAPACITY = 1024;
endpackage

// ===== sim/vertex_weld_remap_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for vertex_weld_remap: random and directed vertex,
// triangle, clear and unused-code beats, checked against an in-bench
// welding predictor. Depends on vwr_pkg, vwr_if, vwr_tb_pkg and its RTL.
module vertex_weld_remap_tb;
  import vwr_pkg::*;
  import vwr_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  vwr_in_if  in_ch ();
  vwr_out_if out_ch ();

  vertex_weld_remap #(.VERTEX_CAPACITY(CAPACITY)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  // Predictor state: the welded positions and the remap of arrival numbers.
  logic [95:0]      weld_pos   [CAPACITY];
  logic [IDX_W-1:0] weld_remap [CAPACITY];
  bit               weld_remap_ok [CAPACITY];
  int               weld_unique;
  int               weld_arrivals;

  in_item_t  pending_beats [$];
  out_item_t expected_results [$];
  logic [95:0] used_positions [$];
  int  error_count;
  int  idle_cycles;
  bit  stall_long;
  bit  hold_send;

  // Appends one beat to the sender's queue.
  function automatic void queue_beat(in_item_t it);
    pending_beats.insert(pending_beats.size(), it);
  endfunction

  function automatic logic [31:0] fold_zero(logic [31:0] v);
    return (v == 32'h8000_0000) ? 32'h0 : v;
  endfunction

  // Works out the result of one accepted beat and updates the welding state.
  function automatic out_item_t weld_predict(in_item_t it);
    out_item_t r;
    logic [95:0] key;
    int hit;
    logic [IDX_W-1:0] ca [3];
    bit ok;
    r = '0;
    hit = -1;
    ok = 1;
    case (op_t'(it.op))
      OP_VERTEX: begin
        if (weld_arrivals >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          key = {fold_zero(it.pos_x), fold_zero(it.pos_y), fold_zero(it.pos_z)};
          for (int i = 0; i < weld_unique; i++) begin
            if (hit < 0 && weld_pos[i] == key) hit = i;
          end
          if (hit < 0 && weld_unique < CAPACITY) begin
            hit = weld_unique;
            weld_pos[hit] = key;
            weld_unique++;
            r.is_new = 1'b1;
          end
          if (hit >= 0) begin
            weld_remap[weld_arrivals] = hit[IDX_W-1:0];
            weld_remap_ok[weld_arrivals] = 1;
            r.index_a = hit[IDX_W-1:0];
          end else begin
            weld_remap_ok[weld_arrivals] = 0;
            r.status = ST_FULL;
          end
          weld_arrivals++;
        end
      end
      OP_TRIANGLE: begin
        ca[0] = it.corner_a;
        ca[1] = it.corner_b;
        ca[2] = it.corner_c;
        for (int k = 0; k < 3; k++) begin
          if (int'(ca[k]) >= weld_arrivals || !weld_remap_ok[ca[k]]) ok = 0;
        end
        if (ok) begin
          r.index_a = weld_remap[ca[0]];
          r.index_b = weld_remap[ca[1]];
          r.index_c = weld_remap[ca[2]];
          r.kept = (r.index_a != r.index_b) && (r.index_b != r.index_c)
                   && (r.index_a != r.index_c);
        end else begin
          r.status = ST_UNSEEN;
        end
      end
      OP_CLEAR: begin
        weld_unique = 0;
        weld_arrivals = 0;
        for (int i = 0; i < CAPACITY; i++) weld_remap_ok[i] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random coordinate, often taken from a small pool so that positions weld.
  function automatic logic [95:0] pick_position();
    logic [95:0] p;
    if (used_positions.size() > 0 && $urandom_range(0, 2) == 0)
      return used_positions[$urandom_range(0, used_positions.size() - 1)];
    p = {$urandom(), $urandom(), $urandom()};
    if ($urandom_range(0, 3) == 0) p[31:0] = 32'h8000_0000;
    if ($urandom_range(0, 7) == 0) p[63:32] = 32'h0;
    used_positions.insert(used_positions.size(), p);
    if (used_positions.size() > 40) void'(used_positions.pop_front());
    return p;
  endfunction

  function automatic in_item_t make_vertex(logic [95:0] p);
    in_item_t it;
    it = '0;
    it.op = OP_VERTEX;
    {it.pos_x, it.pos_y, it.pos_z} = p;
    return it;
  endfunction

  function automatic in_item_t make_triangle(int a, int b, int c);
    in_item_t it;
    it = '0;
    it.op = OP_TRIANGLE;
    it.corner_a = a[IDX_W-1:0];
    it.corner_b = b[IDX_W-1:0];
    it.corner_c = c[IDX_W-1:0];
    return it;
  endfunction

  function automatic in_item_t make_op(op_t code);
    in_item_t it;
    it = {$urandom(), $urandom(), $urandom(), $urandom()};
    it.op = code;
    return it;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: bursts of random length with random gaps.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // The accepted beat leaves the queue here, so the next one is at its head.
      if (in_ch.valid) void'(pending_beats.pop_front());
      if (pending_beats.size() > 0 && !hold_send && gap_left == 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_beats[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // Receiver: its own stall pattern, with a long hold-off on request.
  int stall_count;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_count  <= 0;
    end else if (stall_long) begin
      out_ch.ready <= 1'b0;
      stall_count  <= stall_count + 1;
    end else begin
      stall_count  <= 0;
      out_ch.ready <= ($urandom_range(0, 15) < 11);
    end
  end

  // Predictor runs on accepted input beats; monitor checks result beats.
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && in_ch.valid && in_ch.ready)
      expected_results.insert(expected_results.size(), weld_predict(in_ch.data));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.is_new !== want.is_new) begin
          $error("is_new: expected %0d, got %0d", want.is_new, got.is_new);
          error_count++;
        end
        if (got.kept !== want.kept) begin
          $error("kept: expected %0d, got %0d", want.kept, got.kept);
          error_count++;
        end
        if (got.index_a !== want.index_a) begin
          $error("index_a: expected %0d, got %0d", want.index_a, got.index_a);
          error_count++;
        end
        if (got.index_b !== want.index_b) begin
          $error("index_b: expected %0d, got %0d", want.index_b, got.index_b);
          error_count++;
        end
        if (got.index_c !== want.index_c) begin
          $error("index_c: expected %0d, got %0d", want.index_c, got.index_c);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("vertex_weld_remap_tb: done, errors");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int verts;
    int n;
    bit full_done;
    error_count = 0;
    stall_long  = 0;
    hold_send   = 0;
    full_done   = 0;
    weld_unique = 0;
    weld_arrivals = 0;
    for (int i = 0; i < CAPACITY; i++) weld_remap_ok[i] = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero signs, extremes, NaNs, degenerate and unseen corners.
    queue_beat(make_triangle(0, 0, 0));
    queue_beat(make_vertex(96'h0));
    queue_beat(make_vertex({32'h8000_0000, 32'h8000_0000, 32'h8000_0000}));
    queue_beat(make_vertex({96{1'b1}}));
    queue_beat(make_vertex({32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000}));
    queue_beat(make_vertex({32'h7FC0_0001, 32'h7FC0_0000, 32'h7FC0_0000}));
    queue_beat(make_vertex({32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000}));
    queue_beat(make_vertex({32'h0, 32'h8000_0000, 32'h1}));
    queue_beat(make_triangle(0, 2, 3));
    queue_beat(make_triangle(0, 1, 2));
    queue_beat(make_triangle(3, 5, 4));
    queue_beat(make_triangle(1023, 0, 2));
    queue_beat(make_triangle(0, 7, 1));
    queue_beat(make_op(OP_UNUSED));
    queue_beat(make_op(OP_CLEAR));
    queue_beat(make_triangle(0, 1, 2));
    queue_beat(make_vertex({32'h0, 32'h8000_0000, 32'h1}));
    queue_beat(make_triangle(0, 0, 0));

    // Long receiver hold-off while the sender keeps offering beats.
    for (int i = 0; i < 12; i++) queue_beat(make_vertex(pick_position()));
    stall_long = 1;
    wait (stall_count >= 200);
    stall_long = 0;

    // Sender pause until every expected result has come.
    wait (pending_beats.size() == 0 && !in_ch.valid);
    hold_send = 1;
    wait (expected_results.size() == 0);
    hold_send = 0;
    queue_beat(make_op(OP_CLEAR));

    // Random meshes: vertices then triangles, some noise; one fills the tables.
    n = 0;
    while (n < 1250) begin
      wait (pending_beats.size() < 64);
      if (!full_done && n >= 100) begin
        // Full-capacity mesh: wide unique positions, then overflow items.
        verts = CAPACITY + 2;
        full_done = 1;
      end else begin
        verts = $urandom_range(1, 12);
      end
      for (int v = 0; v < verts; v++) begin
        wait (pending_beats.size() < 64);
        if (verts > CAPACITY) queue_beat(make_vertex({$urandom(), 32'h5, v}));
        else queue_beat(make_vertex(pick_position()));
        n++;
      end
      for (int t = $urandom_range(1, 10); t > 0; t--) begin
        if ($urandom_range(0, 9) == 0)
          queue_beat(make_triangle($urandom_range(0, 1023),
            $urandom_range(0, 1023), $urandom_range(0, 1023)));
        else
          queue_beat(make_triangle($urandom_range(0, verts + 1),
            $urandom_range(0, verts + 1), $urandom_range(0, verts + 1)));
        n++;
      end
      if ($urandom_range(0, 15) == 0) queue_beat(make_op(OP_UNUSED));
      queue_beat(make_op(OP_CLEAR));
      n++;
    end

    // Drain, then watch for any stray beat before the end of the run.
    wait (pending_beats.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("vertex_weld_remap_tb: done, clean");
    end else begin
      $display("vertex_weld_remap_tb: done, errors");
    end
    $finish;
  end
endmodule
